FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Every macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This check is switched off while rst_n is low.
`define MTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// This check is also evaluated during reset.
`define MTB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mtb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtb_pkg: shared types and constants of the timer bank
// Holds the operation, mode, unit and status codes, the per-slot record and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtb_pkg;

  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 32;
  localparam int TV_W     = 16;
  localparam int TICK_W   = 10;
  localparam int NUM_W    = 5;

  localparam int MS_PER_S    = 1000;
  localparam int S_PER_MIN   = 60;
  localparam int MS_PER_MIN  = MS_PER_S * S_PER_MIN;
  localparam int MAX_OUT     = 16;

  typedef enum logic [2:0] {
    OP_CONFIGURE = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_TICK      = 3'd3,
    OP_READ      = 3'd4,
    OP_RELEASE   = 3'd5
  } op_t;

  // Operation codes that the bank takes and drops.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic [1:0] MODE_UNUSED   = 2'd0;
  localparam logic [1:0] MODE_ONESHOT  = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;

  localparam logic [1:0] UNIT_MS  = 2'd0;
  localparam logic [1:0] UNIT_SEC = 2'd1;
  localparam logic [1:0] UNIT_MIN = 2'd2;

  localparam logic [1:0] ST_UNUSED    = 2'd0;
  localparam logic [1:0] ST_STOPPED   = 2'd1;
  localparam logic [1:0] ST_RUNNING   = 2'd2;
  localparam logic [1:0] ST_COMPLETED = 2'd3;

  // One slot as it sits in the slot memory.
  typedef struct packed {
    logic [COUNT_W-1:0] period;
    logic [COUNT_W-1:0] count;
    logic [1:0]         mode;
    logic [1:0]         status;
  } slot_rec_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [1:0]         status;
    logic [COUNT_W-1:0] remaining;
    logic               expired;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP_READ,
    S_OP_EXEC,
    S_TICK_FIRST,
    S_TICK_RUN,
    S_TICK_FLUSH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SRC_IDX,
    SRC_CNT,
    SRC_CNT_NEXT
  } rd_src_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_src_t rd_src;
    logic    op_commit;
    logic    tick_step;
    logic    flush;
  } mtb_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic in_ok;
    logic out_free;
    logic pend_valid;
    logic tick_stall;
    logic cnt_last;
  } mtb_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mtb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtb_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module mtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [ADDR_W-1:0]     raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mtb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtb_ctrl: sequencer of the timer bank
// Takes one request at a time and steps the datapath through a slot
// read-modify-write, or through a sweep of every slot for a tick.
// ----------------------------------------------------------------------------
module mtb_ctrl
  import mtb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mtb_stat_t stat,
  output mtb_cmd_t       cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_src = SRC_IDX;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (stat.in_tick) begin
            state_nxt = S_TICK_FIRST;
          end else if (stat.in_ok) begin
            state_nxt = S_OP_READ;
          end
        end
      end
      S_OP_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_IDX;
        state_nxt  = S_OP_EXEC;
      end
      S_OP_EXEC: begin
        if (stat.out_free) begin
          cmd.op_commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TICK_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_CNT;
        state_nxt  = S_TICK_RUN;
      end
      S_TICK_RUN: begin
        // The slot in the read register is updated unless an expiry has to
        // wait for the output register.
        if (!stat.tick_stall) begin
          cmd.tick_step = 1'b1;
          if (stat.cnt_last) begin
            state_nxt = S_TICK_FLUSH;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = SRC_CNT_NEXT;
          end
        end
      end
      S_TICK_FLUSH: begin
        cmd.flush = 1'b1;
        if (!stat.pend_valid || stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mtb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtb_datapath: slot memory, arithmetic and result registers
// Holds the slot records, the tick step, the unit multiplier, a pending
// expiry register that decides the last marker, and the output register.
// ----------------------------------------------------------------------------
module mtb_datapath
  import mtb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [2:0]        in_op,
  input  wire logic [SLOT_W-1:0] in_idx,
  input  wire logic [TV_W-1:0]   in_tv,
  input  wire logic [1:0]        in_mode,
  input  wire logic [1:0]        in_unit,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_tick,
  input  wire mtb_cmd_t          cmd,
  output mtb_stat_t              stat,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output result_t                out_res
);

  localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int REC_W  = $bits(slot_rec_t);
  localparam int IDX_XW = 7;

  // Latched request fields.
  op_t               op_r;
  logic [SLOT_W-1:0] idx_r;
  logic [TV_W-1:0]   tv_r;
  logic [1:0]        mode_r;
  logic [1:0]        unit_r;
  logic [COUNT_W-1:0] prod_r;
  logic [TICK_W-1:0] tick_ms_r;

  logic [ADDR_W-1:0] cnt_r;
  logic [NUM_W-1:0]  n_r;
  logic [NUM_TIMERS-1:0] valid_r;
  logic              rvalid_r;

  logic              out_valid_r;
  result_t           out_res_r;
  logic              pend_valid_r;
  result_t           pend_res_r;

  logic [ADDR_W-1:0] idx_addr;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              we;
  logic [REC_W-1:0]  ram_rdata;
  slot_rec_t         cur;
  slot_rec_t         op_rec;
  slot_rec_t         tick_rec;
  slot_rec_t         wrec;
  logic [TV_W-1:0]   mult_sel;
  logic [COUNT_W-1:0] prod_nxt;
  logic [COUNT_W-1:0] sub_cnt;
  logic              fire;
  logic              report;
  logic              out_free;
  result_t           op_res;
  result_t           tick_res;
  result_t           flush_res;

  assign idx_addr = ADDR_W'(idx_r);
  assign out_free = !out_valid_r || out_ready;

  // Request decode seen by the sequencer.
  assign stat.in_tick    = (in_op == OP_TICK);
  assign stat.in_ok      = (in_op <= OP_RELEASE) && (in_op != OP_TICK) &&
                           (IDX_XW'(in_idx) < IDX_XW'(NUM_TIMERS));
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid_r;
  assign stat.tick_stall = report && pend_valid_r && !out_free;
  assign stat.cnt_last   = (cnt_r == ADDR_W'(NUM_TIMERS - 1));

  // Request fields are captured at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(in_op);
      idx_r  <= in_idx;
      tv_r   <= in_tv;
      mode_r <= in_mode;
      unit_r <= in_unit;
    end
  end

  // Timeout scaled to milliseconds; registered after the request fields are latched.
  always_comb begin
    mult_sel = (unit_r == UNIT_SEC) ? TV_W'(MS_PER_S) : TV_W'(MS_PER_MIN);
    prod_nxt = COUNT_W'(tv_r) * COUNT_W'(mult_sel);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Tick length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r <= TICK_W'(1);
    end else if (cfg_we) begin
      tick_ms_r <= cfg_tick;
    end
  end

  // Sweep counter and number of reported expiries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r   <= '0;
    end else if (cmd.latch) begin
      cnt_r <= '0;
      n_r   <= '0;
    end else if (cmd.tick_step) begin
      if (!stat.cnt_last) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      if (report) begin
        n_r <= n_r + NUM_W'(1);
      end
    end
  end

  // Slot memory address and write selection.
  always_comb begin
    case (cmd.rd_src)
      SRC_CNT:      raddr = cnt_r;
      SRC_CNT_NEXT: raddr = cnt_r + ADDR_W'(1);
      default:      raddr = idx_addr;
    endcase
    we    = cmd.op_commit || cmd.tick_step;
    waddr = cmd.op_commit ? idx_addr : cnt_r;
    wrec  = cmd.op_commit ? op_rec : tick_rec;
  end

  mtb_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrec),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // A slot that was never written reads as its reset record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rvalid_r <= valid_r[raddr];
      end
    end
  end

  assign cur = rvalid_r ? slot_rec_t'(ram_rdata) : '0;

  // Single-slot operations.
  always_comb begin
    op_rec = cur;
    case (op_r)
      OP_CONFIGURE: begin
        op_rec.mode = mode_r;
        case (unit_r)
          UNIT_MS:  op_rec.period = COUNT_W'(tv_r);
          UNIT_SEC: op_rec.period = prod_r;
          UNIT_MIN: op_rec.period = prod_r;
          default:  op_rec.period = cur.period;
        endcase
      end
      OP_START: begin
        if (cur.period != '0) begin
          op_rec.status = ST_RUNNING;
          op_rec.count  = cur.period;
        end
      end
      OP_STOP: begin
        op_rec.status = ST_STOPPED;
      end
      OP_RELEASE: begin
        op_rec = '0;
      end
      default: begin
        op_rec = cur;
      end
    endcase
    op_res.slot      = idx_r;
    op_res.status    = op_rec.status;
    op_res.remaining = op_rec.count;
    op_res.expired   = 1'b0;
    op_res.last      = 1'b1;
  end

  // One tick on the slot in the read register.
  always_comb begin
    tick_rec = cur;
    fire     = 1'b0;
    sub_cnt  = (cur.count < COUNT_W'(tick_ms_r)) ? '0 : cur.count - COUNT_W'(tick_ms_r);
    if (cur.status == ST_RUNNING) begin
      tick_rec.count = sub_cnt;
      if (sub_cnt == '0) begin
        if (cur.mode == MODE_ONESHOT) begin
          tick_rec.status = ST_COMPLETED;
          fire            = 1'b1;
        end else if (cur.mode == MODE_PERIODIC) begin
          tick_rec.count = cur.period;
          fire           = 1'b1;
        end
      end
    end
    report             = fire && (n_r < NUM_W'(MAX_OUT));
    tick_res.slot      = SLOT_W'(cnt_r);
    tick_res.status    = tick_rec.status;
    tick_res.remaining = tick_rec.count;
    tick_res.expired   = 1'b1;
    tick_res.last      = 1'b0;
  end

  // The final expiry of a sweep leaves with the last marker set.
  always_comb begin
    flush_res      = pend_res_r;
    flush_res.last = 1'b1;
  end

  // Pending expiry: held back until it is known whether another follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.tick_step && report) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush && out_free) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step && report) begin
      pend_res_r <= tick_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op_commit) begin
      out_valid_r <= 1'b1;
      out_res_r   <= op_res;
    end else if (cmd.tick_step && report && pend_valid_r) begin
      out_valid_r <= 1'b1;
      out_res_r   <= pend_res_r;
    end else if (cmd.flush && pend_valid_r && out_free) begin
      out_valid_r <= 1'b1;
      out_res_r   <= flush_res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

FILE: rtl/multi_timer_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_timer_bank: bank of software-style timer slots
// Configure, start, stop, tick, read and release requests on one stream;
// status and expiry results on another.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one request per transfer. Configure, start, stop,
//   read and release act on one slot and return one result (tlast high,
//   tuser low): the slot is read in the cycle after acceptance, then updated
//   once the output register is free, and the result is registered there;
//   the next request is taken only after that update.
//   A tick sweeps every slot, one slot per cycle through the slot memory
//   port while no expiry waits for the output register; no request is
//   taken until the sweep ends. Up to MAX_OUT expiries per tick each give
//   one result with tuser high, in slot order, tlast on the final one; a
//   tick without expiry gives no result. Requests with codes 6 or 7, or
//   with a slot index beyond the bank, are taken and dropped at acceptance.
//   The cfg_ channel writes tick_ms (ms per tick) and is always ready; write
//   it only while the bank is idle.
//   Reset clears all slots to unused with zero counts and tick_ms to 1; no
//   clearing pass is needed. When out_tready is low the result waits in the
//   output register; a sweep holds its place and a single-slot request waits
//   until the register frees.
// ----------------------------------------------------------------------------
module multi_timer_bank
  import mtb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata: operation[2:0], timer_index[6:3], timeout_value[22:7],
  //           timer_mode[24:23], time_unit[26:25], zero fill[31:27]
  input  wire logic [31:0] in_tdata,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: slot[3:0], slot_status[5:4], remaining[37:6], zero fill[39:38]
  output logic [39:0]      out_tdata,
  // out_tuser: expired[0]
  output logic [0:0]       out_tuser,
  output logic             out_tlast,
  // Configuration channel.
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  // cfg_tdata: tick_ms[9:0], zero fill[15:10]
  input  wire logic [15:0] cfg_tdata
);

  mtb_cmd_t  cmd;
  mtb_stat_t stat;
  result_t   res;

  assign cfg_tready = 1'b1;

  mtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tdata[2:0]),
    .in_idx    (in_tdata[6:3]),
    .in_tv     (in_tdata[22:7]),
    .in_mode   (in_tdata[24:23]),
    .in_unit   (in_tdata[26:25]),
    .cfg_we    (cfg_tvalid),
    .cfg_tick  (cfg_tdata[9:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  // Result packing.
  assign out_tdata = {2'b00, res.remaining, res.status, res.slot};
  assign out_tuser = res.expired;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

FILE: rtl/mtb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtb_checker: port-level checks of the timer bank
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtb_checker
  import mtb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tlast
);

  logic out_stall;
  logic bad_op_acc;

  assign out_stall  = out_tvalid && !out_tready;
  assign bad_op_acc = in_tvalid && in_tready &&
                      (in_tdata[2:0] == OP_SPARE_6 || in_tdata[2:0] == OP_SPARE_7);

  // A stalled result holds its payload.
  `MTB_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // Reset leaves no result pending.
  `MTB_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // A status result is always the only result of its request.
  `MTB_ASSERT(a_status_last, out_tvalid && !out_tuser[0] |-> out_tlast, "status result without last")

  // Undefined operation codes are dropped at once.
  `MTB_ASSERT(a_bad_op_drop, bad_op_acc |=> in_tready, "undefined request not dropped")

endmodule

bind multi_timer_bank mtb_checker u_mtb_checker (.*);

`default_nettype wire
